// File: rtl/core/fsr_pkg.sv
// ----------------------------------------------------------------------------
// fsr_pkg
// Types, mode codes and single-precision helpers shared by the reduction block.
// ----------------------------------------------------------------------------
package fsr_pkg;

    typedef enum logic [1:0] {
        MODE_SUM    = 2'd0,
        MODE_MAX    = 2'd1,
        MODE_MAXABS = 2'd2,
        MODE_MIN    = 2'd3
    } mode_t;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [31:0] POS_ZERO  = 32'h0000_0000;

    // One queued item with the classification done by the front part.
    typedef struct packed {
        logic [31:0] bits;
        logic [31:0] abs_bits;
        logic        is_nan;
        logic        abs_zero;
        logic        last;
    } item_t;

    function automatic logic is_nan(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
    endfunction

    // Strict greater-than; false on any NaN and on two zeros of either sign.
    function automatic logic fp_gt(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] ka;
        logic [31:0] kb;
        ka = a[31] ? ~a : (a | 32'h8000_0000);
        kb = b[31] ? ~b : (b | 32'h8000_0000);
        if (is_nan(a) || is_nan(b)) begin
            return 1'b0;
        end
        if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
            return 1'b0;
        end
        return ka > kb;
    endfunction

    // IEEE single add, round to nearest even, subnormals kept, NaN canonical.
    function automatic logic [31:0] fp_add(input logic [31:0] x, input logic [31:0] y);
        logic [31:0] a;
        logic [31:0] b;
        logic [9:0]  ea;
        logic [9:0]  eb;
        logic [9:0]  e;
        logic [7:0]  diff;
        logic [26:0] ma;
        logic [26:0] mb;
        logic [26:0] mbs;
        logic [26:0] lost;
        logic [27:0] sum;
        logic [26:0] m;
        logic [4:0]  lz;
        logic        found;
        logic [9:0]  sh;
        logic        rup;
        logic [24:0] mant;
        logic        xnan;
        logic        ynan;
        logic        xinf;
        logic        yinf;
        xnan = is_nan(x);
        ynan = is_nan(y);
        xinf = (x[30:0] == 31'h7F80_0000);
        yinf = (y[30:0] == 31'h7F80_0000);
        if (xnan || ynan || (xinf && yinf && (x[31] != y[31]))) begin
            return CANON_NAN;
        end
        if (xinf) begin
            return x;
        end
        if (yinf) begin
            return y;
        end
        if (x[30:0] >= y[30:0]) begin
            a = x;
            b = y;
        end else begin
            a = y;
            b = x;
        end
        ea = (a[30:23] == 8'd0) ? 10'd1 : {2'b00, a[30:23]};
        eb = (b[30:23] == 8'd0) ? 10'd1 : {2'b00, b[30:23]};
        ma = {(a[30:23] != 8'd0), a[22:0], 3'b000};
        mb = {(b[30:23] != 8'd0), b[22:0], 3'b000};
        diff = 8'(ea - eb);
        if (diff >= 8'd27) begin
            mbs = {26'd0, (mb != 27'd0)};
        end else begin
            lost = mb & ((27'd1 << diff) - 27'd1);
            mbs  = (mb >> diff) | {26'd0, (lost != 27'd0)};
        end
        e = ea;
        if (a[31] == b[31]) begin
            sum = {1'b0, ma} + {1'b0, mbs};
            if (sum[27]) begin
                m = {sum[27:2], sum[1] | sum[0]};
                e = ea + 10'd1;
            end else begin
                m = sum[26:0];
            end
        end else begin
            sum = {1'b0, ma} - {1'b0, mbs};
            if (sum == 28'd0) begin
                return POS_ZERO;
            end
            lz    = 5'd0;
            found = 1'b0;
            for (int i = 26; i >= 0; i--) begin
                if (!found && sum[i]) begin
                    found = 1'b1;
                    lz    = 5'(26 - i);
                end
            end
            sh = ({5'd0, lz} < (ea - 10'd1)) ? {5'd0, lz} : (ea - 10'd1);
            m  = sum[26:0] << sh;
            e  = ea - sh;
        end
        rup  = m[2] & (m[1] | m[0] | m[3]);
        mant = {1'b0, m[26:3]} + {24'd0, rup};
        if (mant[24]) begin
            mant = mant >> 1;
            e    = e + 10'd1;
        end
        if (e >= 10'd255) begin
            return {a[31], 8'hFF, 23'd0};
        end
        return {a[31], (mant[23] ? e[7:0] : 8'd0), mant[22:0]};
    endfunction

endpackage

// File: rtl/core/fsr_front.sv
// ----------------------------------------------------------------------------
// fsr_front
// Input stage: accept items and classify them for the back part.
// ----------------------------------------------------------------------------
module fsr_front import fsr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_element_bits,
    input  logic        s_is_last,
    output logic        push_valid,
    input  logic        push_ready,
    output item_t       push_item
);

    logic  hold_reg;
    item_t item_reg;
    item_t item_next;

    assign s_ready    = !hold_reg || push_ready;
    assign push_valid = hold_reg;
    assign push_item  = item_reg;

    always_comb begin
        item_next.bits     = s_element_bits;
        item_next.abs_bits = {1'b0, s_element_bits[30:0]};
        item_next.is_nan   = is_nan(s_element_bits);
        item_next.abs_zero = (s_element_bits[30:0] == 31'd0);
        item_next.last     = s_is_last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg <= 1'b0;
        end else if (s_ready) begin
            hold_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= item_next;
        end
    end

endmodule

// File: rtl/core/fsr_queue.sv
// ----------------------------------------------------------------------------
// fsr_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module fsr_queue import fsr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push_valid,
    output logic  push_ready,
    input  item_t push_item,
    output logic  pop_valid,
    input  logic  pop_ready,
    output item_t pop_item
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic        push;
    logic        pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: rtl/core/fsr_back.sv
// ----------------------------------------------------------------------------
// fsr_back
// Accumulate items in the selected mode and hold the result for the output.
// ----------------------------------------------------------------------------
module fsr_back import fsr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  mode_t       mode,
    input  logic        pop_valid,
    output logic        pop_ready,
    input  item_t       pop_item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_reduced_bits
);

    logic [31:0] acc_reg;
    logic [31:0] acc_next;
    logic        first_reg;
    logic        out_valid_reg;
    logic [31:0] out_reg;
    logic [31:0] base;
    logic        take;

    assign pop_ready      = !out_valid_reg || m_ready;
    assign take           = pop_valid && pop_ready;
    assign m_valid        = out_valid_reg;
    assign m_reduced_bits = out_reg;

    always_comb begin
        if (first_reg) begin
            base = ((mode == MODE_MAX) || (mode == MODE_MIN)) ? pop_item.bits : POS_ZERO;
        end else begin
            base = acc_reg;
        end
        acc_next = base;
        unique case (mode)
            MODE_SUM: begin
                acc_next = fp_add(base, pop_item.bits);
            end
            MODE_MAX: begin
                if (!pop_item.is_nan && fp_gt(pop_item.bits, base)) begin
                    acc_next = pop_item.bits;
                end
            end
            MODE_MAXABS: begin
                if (!pop_item.is_nan && !pop_item.abs_zero && fp_gt(pop_item.abs_bits, base)) begin
                    acc_next = pop_item.abs_bits;
                end
            end
            MODE_MIN: begin
                if (!pop_item.is_nan && fp_gt(base, pop_item.bits)) begin
                    acc_next = pop_item.bits;
                end
            end
            default: begin
                acc_next = base;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= POS_ZERO;
            first_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (take) begin
                acc_reg   <= acc_next;
                first_reg <= pop_item.last;
                if (pop_item.last) begin
                    out_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take && pop_item.last) begin
            out_reg <= acc_next;
        end
    end

endmodule

// File: rtl/core/float_stream_reduction.sv
// ----------------------------------------------------------------------------
// float_stream_reduction
// Reduce a run of single-precision values to sum, max, max-abs or min.
// ----------------------------------------------------------------------------
// Takes one element per cycle when neither side stalls; the throughput is set
// by the back part's accumulator loop, which does one full single-precision
// add or compare per cycle. An element passes the input register, then the
// two-entry queue, before it reaches the accumulator, and the result of a run
// shows on m_valid right after the edge that accumulates its last element.
// The sum rounds to nearest even in arrival order, keeps subnormals and turns
// every NaN it makes into 0x7FC00000. Max and min start from the first
// element; a NaN never replaces the running value. Write cfg_reduce_mode
// only while no run is in flight.
module float_stream_reduction import fsr_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_reduce_mode,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_element_bits,
    input  logic        s_is_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_reduced_bits
);

    mode_t mode_reg;
    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    // The mode register takes a write in any cycle.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_SUM;
        end else if (cfg_valid) begin
            mode_reg <= mode_t'(cfg_reduce_mode);
        end
    end

    // Front: accept and classify each item.
    fsr_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_element_bits (s_element_bits),
        .s_is_last      (s_is_last),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_item      (push_item)
    );

    // Queue: decouple front and back stalls.
    fsr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    // Back: accumulate and hold the run result.
    fsr_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .mode           (mode_reg),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_item       (pop_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_reduced_bits (m_reduced_bits)
    );

endmodule

// File: rtl/core/fsr_checker.sv
// ----------------------------------------------------------------------------
// fsr_checker
// Port-level checks for the reduction block, bound to the top level.
// ----------------------------------------------------------------------------
module fsr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        cfg_ready,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [31:0] m_reduced_bits
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_reduced_bits))
        else $error("result changed while stalled");

    a_cfg_ready: assert property (@(posedge aclk) cfg_ready)
        else $error("configuration port not ready");

    a_no_out_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result shown right after reset");

    a_ready_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(s_ready) |-> $past(s_valid))
        else $error("input stalled without a held item");

endmodule

bind float_stream_reduction fsr_checker u_fsr_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .cfg_ready      (cfg_ready),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_reduced_bits (m_reduced_bits)
);

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for float_stream_reduction: streams runs of single
// values in every reduce mode under several idle/stall mixes and compares each
// emitted reduction with a bit-exact integer model of sum, max, maxabs and min.
// ----------------------------------------------------------------------------
module tb_top;
    import fsr_pkg::*;

    localparam int PERIOD     = 4;
    localparam int DRAIN_WAIT = 8;    // pipeline depth plus margin

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_reduce_mode = MODE_SUM;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_element_bits = '0;
    logic        s_is_last = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_reduced_bits;

    float_stream_reduction uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_reduce_mode (cfg_reduce_mode),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_element_bits  (s_element_bits),
        .s_is_last       (s_is_last),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_reduced_bits  (m_reduced_bits)
    );

    always #(PERIOD / 2) aclk = ~aclk;

    // Model state: running value, run-start flag and the active mode.
    logic [31:0] model_acc = '0;
    logic        model_first = 1'b1;
    mode_t       model_mode = MODE_SUM;

    logic [31:0] expected_sums[$];   // reductions waiting to come out
    int          send_idle_pct = 0;
    int          sink_stall_pct = 0;
    int          mismatches = 0;
    int          items_sent = 0;
    int          results_seen = 0;
    int          cfg_writes = 0;

    // ------------------------------------------------------------------------
    // Bit-exact single-precision helpers
    // ------------------------------------------------------------------------
    function automatic logic nan_bits(input logic [31:0] b);
        return (b[30:23] == 8'hFF) && (b[22:0] != 0);
    endfunction

    // Magnitude as an integer in units of the smallest subnormal.
    function automatic logic [279:0] magnitude(input logic [31:0] b);
        logic [279:0] v;
        if (b[30:23] == 8'd0) begin
            v = 280'(b[22:0]);
        end else begin
            v = 280'({1'b1, b[22:0]}) << (b[30:23] - 1);
        end
        return v;
    endfunction

    // Exact sum, then one rounding to nearest even.
    function automatic logic [31:0] single_add(input logic [31:0] x, input logic [31:0] y);
        logic [279:0] mx;
        logic [279:0] my;
        logic [279:0] v;
        logic [279:0] rem;
        logic [279:0] half;
        logic [31:0]  keep;
        logic [31:0]  r;
        logic         s;
        int           p;
        int           sh;
        if (nan_bits(x) || nan_bits(y)) return CANON_NAN;
        if (x[30:0] == 31'h7F80_0000 && y[30:0] == 31'h7F80_0000 && x[31] != y[31])
            return CANON_NAN;
        if (x[30:0] == 31'h7F80_0000) return x;
        if (y[30:0] == 31'h7F80_0000) return y;
        mx = magnitude(x);
        my = magnitude(y);
        if (x[31] == y[31]) begin
            v = mx + my;
            s = x[31];
        end else if (mx >= my) begin
            v = mx - my;
            s = x[31];
        end else begin
            v = my - mx;
            s = y[31];
        end
        // Exact zero: negative only when both inputs are negative zeros.
        if (v == 0) return {x[31] & y[31], 31'd0};
        p = 0;
        for (int i = 279; i >= 0; i--) begin
            if (v[i] && p == 0) p = i;
        end
        if (p <= 23) return {s, v[30:0]};
        sh   = p - 23;
        keep = 32'(v >> sh);
        rem  = v & ((280'd1 << sh) - 1);
        half = 280'd1 << (sh - 1);
        if (rem > half || (rem == half && keep[0])) keep = keep + 1;
        // A carry out of the mantissa bumps the exponent field by itself.
        r = (32'(sh) << 23) + keep;
        if (r >= 32'h7F80_0000) r = 32'h7F80_0000;
        return {s, r[30:0]};
    endfunction

    function automatic logic single_gt(input logic [31:0] a, input logic [31:0] b);
        logic signed [32:0] oa;
        logic signed [32:0] ob;
        if (nan_bits(a) || nan_bits(b)) return 1'b0;
        oa = a[31] ? -$signed({2'b00, a[30:0]}) : $signed({2'b00, a[30:0]});
        ob = b[31] ? -$signed({2'b00, b[30:0]}) : $signed({2'b00, b[30:0]});
        return oa > ob;   // both zeros map to 0, so they never replace
    endfunction

    // Advance the model by one accepted item.
    task automatic reduce_item(input logic [31:0] elem, input logic last);
        logic [31:0] a;
        if (model_first) begin
            model_acc   = (model_mode == MODE_MAX || model_mode == MODE_MIN) ? elem : POS_ZERO;
            model_first = 1'b0;
        end
        case (model_mode)
            MODE_SUM: begin
                model_acc = single_add(model_acc, elem);
            end
            MODE_MAX: begin
                if (single_gt(elem, model_acc)) model_acc = elem;
            end
            MODE_MAXABS: begin
                a = {1'b0, elem[30:0]};
                if (single_gt(a, model_acc)) model_acc = a;
            end
            default: begin
                if (single_gt(model_acc, elem)) model_acc = elem;
            end
        endcase
        if (last) begin
            expected_sums.push_back(model_acc);
            model_first = 1'b1;
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("MISMATCH %s: got %08h expected %08h at %0t", what, got, want, $realtime);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, compare each item with the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_sums.size() == 0) begin
                report_mismatch("unexpected result", m_reduced_bits, 32'h0);
            end else if (m_reduced_bits !== expected_sums[0]) begin
                report_mismatch("reduced_bits", m_reduced_bits, expected_sums.pop_front());
            end else begin
                void'(expected_sums.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    // Hold valid and payload until accepted; idle first at random.
    task automatic send_item(input logic [31:0] elem, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_element_bits <= elem;
        s_is_last      <= last;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
        reduce_item(elem, last);
    endtask

    // Drop valid and wait until every expected item has come out.
    task automatic drain;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_sums.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic write_mode(input mode_t mode);
        drain();
        cfg_valid       <= 1'b1;
        cfg_reduce_mode <= mode;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        model_mode = mode;
        cfg_writes++;
    endtask

    function automatic logic [31:0] pick_element();
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(11))
            0: return {r[31], 31'd0};                        // signed zero
            1: return {r[31], 8'hFF, 23'd0};                 // infinity
            2: return {r[31], 8'hFF, r[22:1], 1'b1};         // NaN
            3: return {r[31], 8'd0, r[22:0]};                // subnormal
            4: return {r[31], 8'hFE, r[22:0]};               // near overflow
            5, 6, 7: return {r[31], 8'(8'd124 + r[25:23]), r[22:0]};  // close range
            default: return r;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_sum_cases;
        write_mode(MODE_SUM);
        send_item(32'h3F80_0000, 1'b0);   // 1.0
        send_item(32'hBF80_0000, 1'b1);   // -1.0, exact cancel gives +0
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h8000_0000, 1'b1);   // -0 + -0
        send_item(32'h7F7F_FFFF, 1'b0);
        send_item(32'h7F7F_FFFF, 1'b1);   // overflow to infinity
        send_item(32'h7F80_0000, 1'b0);
        send_item(32'hFF80_0000, 1'b1);   // inf - inf is canonical NaN
        send_item(32'h0000_0001, 1'b0);
        send_item(32'h807F_FFFF, 1'b1);   // subnormals
        send_item(32'h4B80_0000, 1'b0);
        send_item(32'h3F80_0000, 1'b1);   // tie, rounds to even
        send_item(32'hFFFF_FFFF, 1'b1);   // NaN alone
    endtask

    task automatic test_compare_cases;
        write_mode(MODE_MAX);
        send_item(32'h7FA0_0001, 1'b0);   // NaN first element keeps its bits
        send_item(32'h4000_0000, 1'b1);
        send_item(32'h8000_0000, 1'b0);
        send_item(32'h0000_0000, 1'b1);   // zeros do not replace
        write_mode(MODE_MAXABS);
        send_item(32'hFF80_0000, 1'b0);
        send_item(32'h7FC0_0000, 1'b1);
        write_mode(MODE_MIN);
        send_item(32'h3F80_0000, 1'b0);
        send_item(32'hFFC0_0000, 1'b0);   // NaN never replaces
        send_item(32'hFF80_0000, 1'b1);
        // Mode change inside a run works on the accumulator as it stands.
        send_item(32'h4040_0000, 1'b0);
        write_mode(MODE_SUM);
        send_item(32'h3F80_0000, 1'b1);
    endtask

    task automatic test_random_runs(input int n_items);
        int   left;
        int   len;
        logic last;
        left = n_items;
        while (left > 0) begin
            write_mode(mode_t'($urandom_range(3)));
            // Mostly short runs; a few long ones stress accumulation.
            len = ($urandom_range(9) == 0) ? $urandom_range(40, 20) : $urandom_range(8, 1);
            for (int i = 0; i < len; i++) begin
                last = (i == len - 1) || (left <= 1);
                send_item(pick_element(), last);
                left--;
                if (last) break;
            end
        end
    endtask

    task automatic set_idling(input int send_pct, input int stall_pct);
        drain();
        send_idle_pct  = send_pct;
        sink_stall_pct = stall_pct;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_sum_cases();
        test_compare_cases();
        set_idling(0, 0);
        test_random_runs(340);
        set_idling(86, 0);
        test_random_runs(320);
        set_idling(0, 86);
        test_random_runs(320);
        set_idling(29, 29);
        test_random_runs(340);
        drain();
        repeat (20) @(posedge aclk);
        $display("Covered %0d items in %0d runs across all four modes, %0d mode writes,",
                 items_sent, results_seen, cfg_writes);
        $display("with free-running, idle-sender, stalled-sink and mixed handshakes.");
        if (mismatches == 0 && expected_sums.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // Stop a hung run.
    initial begin
        #4000000;
        $display("Timeout with %0d results outstanding", expected_sums.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
